// ----- rtl/prs80_pkg.sv -----
// ----------------------------------------------------------------------------
// prs80_pkg
// Shared types, constants and round functions for the PRESENT-80 encryptor.
// ----------------------------------------------------------------------------
package prs80_pkg;

    // Sizes
    localparam int BLOCK_W     = 64;
    localparam int KEY_W       = 80;
    localparam int KEY_HIGH_W  = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 8;
    localparam int RC_W        = 5;

    // Default number of full rounds
    localparam int ROUND_COUNT_DEF = 31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd1;

    // 4-bit S-box
    localparam logic [3:0] SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    // One pipeline slot: valid bit, cipher state and the key register for it
    typedef struct packed {
        logic                 valid;
        logic [BLOCK_W-1:0]   state;
        logic [KEY_W-1:0]     key;
    } stage_t;

    // Round key is the top 64 bits of the key register
    function automatic logic [BLOCK_W-1:0] round_key(input logic [KEY_W-1:0] k);
        return k[KEY_W-1 -: BLOCK_W];
    endfunction

    // S-box on every nibble
    function automatic logic [BLOCK_W-1:0] sub_layer(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            r[4*n +: 4] = SBOX[s[4*n +: 4]];
        end
        return r;
    endfunction

    // Bit permutation: bit i goes to 16*i mod 63, bit 63 stays
    function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int i = 0; i < BLOCK_W; i++) begin
            if (i == BLOCK_W - 1)
                r[BLOCK_W-1] = s[i];
            else
                r[6'((16 * i) % (BLOCK_W - 1))] = s[i];
        end
        return r;
    endfunction

    // Key schedule step: rotate left 61, S-box top nibble, XOR counter at 19..15
    function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                     input logic [RC_W-1:0]  rc);
        logic [KEY_W-1:0] n;
        n = {k[18:0], k[KEY_W-1:19]};
        n[KEY_W-1 -: 4] = SBOX[n[KEY_W-1 -: 4]];
        n[19:15] = n[19:15] ^ rc;
        return n;
    endfunction

endpackage

// ----- rtl/present80_block_encrypt.sv -----
// ----------------------------------------------------------------------------
// present80_block_encrypt
// Each accepted word passes through the round registers, then the output register.
// Throughput: one word per cycle unless the output stalls; one round per
// pipeline register stage, the final key addition sits in the output register.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Reset clears all valid bits and both key registers to zero.
// ----------------------------------------------------------------------------
module present80_block_encrypt #(
    parameter int ROUND_COUNT = prs80_pkg::ROUND_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_we,
    input  logic [prs80_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prs80_pkg::CFG_DATA_W-1:0] cfg_data,
    // input words
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [prs80_pkg::BLOCK_W-1:0]    plaintext,
    // output words
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [prs80_pkg::BLOCK_W-1:0]    ciphertext
);
    import prs80_pkg::*;

    logic [KEY_HIGH_W-1:0]     key_high_reg;
    logic [BLOCK_W-1:0]        key_low_reg;
    logic                      en;
    stage_t                    stage [0:ROUND_COUNT];
    logic [ROUND_COUNT-1:0]    valid_vec;
    logic                      out_valid_reg;
    logic [BLOCK_W-1:0]        ciphertext_reg;

    // Key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_KEY_HIGH)
                key_high_reg <= cfg_data[KEY_HIGH_W-1:0];
            else if (cfg_index == REG_KEY_LOW)
                key_low_reg <= cfg_data;
        end
    end

    // Pipeline advances whenever the output slot is free or being taken
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Pipeline entry
    assign stage[0].valid = in_valid;
    assign stage[0].state = plaintext;
    assign stage[0].key   = {key_high_reg, key_low_reg};

    // Round stages
    for (genvar g = 0; g < ROUND_COUNT; g++)
    begin : g_round
        prs80_round #(
            .ROUND_IDX (g + 1)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage_in  (stage[g]),
            .stage_out (stage[g+1])
        );
        assign valid_vec[g] = stage[g+1].valid;
    end

    // Output register with final key addition
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= stage[ROUND_COUNT].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && stage[ROUND_COUNT].valid)
            ciphertext_reg <= stage[ROUND_COUNT].state ^ round_key(stage[ROUND_COUNT].key);
    end

    assign out_valid  = out_valid_reg;
    assign ciphertext = ciphertext_reg;

    // Checks
    // a stall freezes every stage
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_vec))
        else $error("pipeline moved during stall");

    // first stage takes the input valid when advancing
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> valid_vec[0] == $past(in_valid))
        else $error("first stage valid mismatch");

    // last stage word reaches the output register
    a_exit: assert property (@(posedge clk) disable iff (!rst_n)
        en && valid_vec[ROUND_COUNT-1] |=> out_valid)
        else $error("word lost at output");

endmodule

// ----- rtl/prs80_round.sv -----
// ----------------------------------------------------------------------------
// prs80_round
// One registered cipher round: add round key, S-box layer, permutation,
// and the matching key schedule step for the word it carries.
// ----------------------------------------------------------------------------
module prs80_round #(
    parameter int ROUND_IDX = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  prs80_pkg::stage_t stage_in,
    output prs80_pkg::stage_t stage_out
);
    import prs80_pkg::*;

    localparam logic [RC_W-1:0] RC = RC_W'(ROUND_IDX);

    logic               valid_reg;
    logic [BLOCK_W-1:0] state_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [BLOCK_W-1:0] state_next;
    logic [KEY_W-1:0]   key_next;

    // Round datapath
    always_comb
    begin
        state_next = perm_layer(sub_layer(stage_in.state ^ round_key(stage_in.key)));
        key_next   = key_update(stage_in.key, RC);
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= stage_in.valid;
    end

    // Payload, loaded only for a live word
    always_ff @(posedge clk)
    begin
        if (en && stage_in.valid)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.state = state_reg;
    assign stage_out.key   = key_reg;

endmodule
